### design/gnss_binary_frame_parser_defines.svh
// Assertion macros shared by the frame parser RTL.
// Depends on clk_i and rst_ni being visible in the asserting module.
`ifndef GNSS_BINARY_FRAME_PARSER_DEFINES_SVH
`define GNSS_BINARY_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define GBFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define GBFP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/gbfp_pkg.sv
// Package for the GNSS binary frame parser: protocol constants, field tables,
// parse phases and the microcode program. No dependencies.
`default_nettype none

package gbfp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;
  localparam logic [7:0] CLASS_NAV   = 8'h01;
  localparam logic [7:0] ID_POS      = 8'h07;
  localparam logic [7:0] ID_REL      = 8'h3C;

  localparam logic [6:0] POS_LEN  = 7'd98;
  localparam logic [6:0] POS_CK   = 7'd96;
  localparam logic [6:0] REL_LEN  = 7'd46;
  localparam logic [6:0] REL_CK   = 7'd44;
  localparam logic [6:0] BUF_DEPTH = 7'd98;

  localparam logic [4:0] POS_LAST_FIELD = 5'd28;
  localparam logic [4:0] REL_LAST_FIELD = 5'd2;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_POS  = 2'd1;
  localparam logic [1:0] KIND_REL  = 2'd2;

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_CLASS = 3'd2,
    PH_ID    = 3'd3,
    PH_BODY  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_WAIT  = 3'd0,
    ST_PROC  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_FSET  = 3'd3,
    ST_READ  = 3'd4,
    ST_ACC   = 3'd5,
    ST_EMIT  = 3'd6
  } step_e;

  typedef enum logic [2:0] {
    ACT_TAKE       = 3'd0,
    ACT_PROC       = 3'd1,
    ACT_EMIT_EMPTY = 3'd2,
    ACT_FSET       = 3'd3,
    ACT_READ       = 3'd4,
    ACT_ACC        = 3'd5,
    ACT_EMIT_FIELD = 3'd6
  } act_e;

  typedef enum logic [1:0] {
    HOLD_NONE     = 2'd0,
    HOLD_IN_VALID = 2'd1,
    HOLD_OUT_FREE = 2'd2
  } hold_e;

  typedef enum logic [1:0] {
    BR_ALWAYS     = 2'd0,
    BR_GOOD       = 2'd1,
    BR_K_ZERO     = 2'd2,
    BR_LAST_FIELD = 2'd3
  } br_e;

  typedef struct packed {
    act_e  act;
    hold_e hold;
    br_e   br;
    step_e tgt_t;
    step_e tgt_f;
  } cw_t;

  // Microcode program: one control word per step.
  function automatic cw_t ucode(input step_e s);
    cw_t cw;
    unique case (s)
      ST_WAIT:  cw = '{ACT_TAKE,       HOLD_IN_VALID, BR_ALWAYS,     ST_PROC, ST_PROC};
      ST_PROC:  cw = '{ACT_PROC,       HOLD_NONE,     BR_GOOD,       ST_FSET, ST_EMPTY};
      ST_EMPTY: cw = '{ACT_EMIT_EMPTY, HOLD_OUT_FREE, BR_ALWAYS,     ST_WAIT, ST_WAIT};
      ST_FSET:  cw = '{ACT_FSET,       HOLD_NONE,     BR_ALWAYS,     ST_READ, ST_READ};
      ST_READ:  cw = '{ACT_READ,       HOLD_NONE,     BR_ALWAYS,     ST_ACC,  ST_ACC};
      ST_ACC:   cw = '{ACT_ACC,        HOLD_NONE,     BR_K_ZERO,     ST_EMIT, ST_READ};
      ST_EMIT:  cw = '{ACT_EMIT_FIELD, HOLD_OUT_FREE, BR_LAST_FIELD, ST_WAIT, ST_FSET};
      default:  cw = '{ACT_TAKE,       HOLD_IN_VALID, BR_ALWAYS,     ST_PROC, ST_PROC};
    endcase
    return cw;
  endfunction

  // Buffer offset of a position frame field, counted from the class byte.
  function automatic logic [6:0] pos_off(input logic [4:0] idx);
    logic [6:0] off;
    unique case (idx)
      5'd0:  off = 7'd4;
      5'd1:  off = 7'd8;
      5'd2:  off = 7'd10;
      5'd3:  off = 7'd11;
      5'd4:  off = 7'd12;
      5'd5:  off = 7'd13;
      5'd6:  off = 7'd14;
      5'd7:  off = 7'd15;
      5'd8:  off = 7'd16;
      5'd9:  off = 7'd20;
      5'd10: off = 7'd24;
      5'd11: off = 7'd25;
      5'd12: off = 7'd26;
      5'd13: off = 7'd27;
      5'd14: off = 7'd28;
      5'd15: off = 7'd32;
      5'd16: off = 7'd36;
      5'd17: off = 7'd40;
      5'd18: off = 7'd44;
      5'd19: off = 7'd48;
      5'd20: off = 7'd52;
      5'd21: off = 7'd56;
      5'd22: off = 7'd60;
      5'd23: off = 7'd64;
      5'd24: off = 7'd68;
      5'd25: off = 7'd72;
      5'd26: off = 7'd76;
      5'd27: off = 7'd80;
      5'd28: off = 7'd88;
      default: off = 7'd0;
    endcase
    return off;
  endfunction

  // Size of a position frame field in bytes, minus one.
  function automatic logic [1:0] pos_size_m1(input logic [4:0] idx);
    logic [1:0] sz;
    unique case (idx)
      5'd0, 5'd8, 5'd9:                 sz = 2'd3;
      5'd1, 5'd27:                      sz = 2'd1;
      5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7,
      5'd10, 5'd11, 5'd12, 5'd13:       sz = 2'd0;
      default:                          sz = 2'd3;
    endcase
    return sz;
  endfunction

endpackage

`default_nettype wire

### design/gnss_binary_frame_parser.sv
// Top level of the GNSS binary frame parser: microcoded sequencer, frame buffer
// and output register. Depends on gbfp_pkg and gnss_binary_frame_parser_defines.svh.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o  | rx_byte_i
//   out     | output    | out_valid_o / out_stall_i| frame_kind_o, field_index_o,
//           |           |                         | field_value_o, last_o
//
// A byte that decodes nothing runs the take, decode and answer steps, then waits;
// its result word is registered by the answer step. A good frame adds per field a set
// step, a read and an accumulate step per byte through the one-byte read port of the
// frame buffer and an emit step; after the last field the sequencer takes bytes.
// Reset clears the phase, counters, sums and step; the buffer needs no clearing.
// A stalled output holds the answer or emit step until the word is taken.
`default_nettype none
`include "gnss_binary_frame_parser_defines.svh"

module gnss_binary_frame_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       frame_kind_o,
  output logic [4:0]       field_index_o,
  output logic [31:0]      field_value_o,
  output logic             last_o
);

  gbfp_pkg::step_e  step_q, step_d;
  gbfp_pkg::cw_t    cw;
  gbfp_pkg::phase_e phase_q, phase_d;

  logic [7:0]  byte_q;
  logic [6:0]  count_q, count_d;
  logic        type_q, type_d;
  logic [7:0]  suma_q, suma_d, sumb_q, sumb_d;
  logic [7:0]  cka_q, cka_d;
  logic [4:0]  fld_q;
  logic [1:0]  k_q;
  logic [31:0] acc_q;
  logic [7:0]  rdata_q;
  logic [7:0]  mem [gbfp_pkg::BUF_DEPTH];

  logic        go, br_true, good, out_free, last_field;
  logic        store, we;
  logic [6:0]  ckpos, len, cnt_base, waddr, raddr, off;
  logic [7:0]  sa_base, sb_base;
  logic [1:0]  size_m1;

  logic        out_valid_q;
  logic [1:0]  kind_q;
  logic [4:0]  idx_q;
  logic [31:0] value_q;
  logic        last_q;

  assign cw       = gbfp_pkg::ucode(step_q);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    unique case (cw.hold)
      gbfp_pkg::HOLD_IN_VALID: go = in_valid_i;
      gbfp_pkg::HOLD_OUT_FREE: go = out_free;
      default:                 go = 1'b1;
    endcase
  end

  assign in_stall_o = (cw.hold != gbfp_pkg::HOLD_IN_VALID);

  assign last_field = type_q ? (fld_q == gbfp_pkg::REL_LAST_FIELD)
                             : (fld_q == gbfp_pkg::POS_LAST_FIELD);
  assign off        = type_q ? (7'd12 + {fld_q[1:0], 2'b00}) : gbfp_pkg::pos_off(fld_q);
  assign size_m1    = type_q ? 2'd3 : gbfp_pkg::pos_size_m1(fld_q);
  assign raddr      = off + {5'd0, k_q};
  assign len        = type_q ? gbfp_pkg::REL_LEN : gbfp_pkg::POS_LEN;

  // Byte decode: phase transitions, buffer store and running check sums.
  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    type_d   = type_q;
    suma_d   = suma_q;
    sumb_d   = sumb_q;
    cka_d    = cka_q;
    store    = 1'b0;
    ckpos    = type_q ? gbfp_pkg::REL_CK : gbfp_pkg::POS_CK;
    cnt_base = count_q;
    sa_base  = suma_q;
    sb_base  = sumb_q;
    good     = 1'b0;
    unique case (phase_q)
      gbfp_pkg::PH_SYNC2: begin
        phase_d = (byte_q == gbfp_pkg::SYNC_SECOND) ? gbfp_pkg::PH_CLASS : gbfp_pkg::PH_SYNC1;
        count_d = 7'd0;
      end
      gbfp_pkg::PH_CLASS: begin
        if (byte_q == gbfp_pkg::CLASS_NAV) begin
          store    = 1'b1;
          ckpos    = gbfp_pkg::POS_CK;
          cnt_base = 7'd0;
          sa_base  = 8'd0;
          sb_base  = 8'd0;
          phase_d  = gbfp_pkg::PH_ID;
        end else begin
          phase_d = gbfp_pkg::PH_SYNC1;
          count_d = 7'd0;
        end
      end
      gbfp_pkg::PH_ID: begin
        if (byte_q == gbfp_pkg::ID_POS || byte_q == gbfp_pkg::ID_REL) begin
          type_d  = (byte_q == gbfp_pkg::ID_REL);
          ckpos   = type_d ? gbfp_pkg::REL_CK : gbfp_pkg::POS_CK;
          store   = 1'b1;
          phase_d = gbfp_pkg::PH_BODY;
        end else begin
          phase_d = gbfp_pkg::PH_SYNC1;
          count_d = 7'd0;
        end
      end
      gbfp_pkg::PH_BODY: begin
        store = 1'b1;
      end
      default: begin
        phase_d = (byte_q == gbfp_pkg::SYNC_FIRST) ? gbfp_pkg::PH_SYNC2 : gbfp_pkg::PH_SYNC1;
      end
    endcase
    if (store) begin
      suma_d = sa_base;
      sumb_d = sb_base;
      if (cnt_base < ckpos) begin
        suma_d = sa_base + byte_q;
        sumb_d = sb_base + suma_d;
      end
      if (cnt_base == ckpos) begin
        cka_d = byte_q;
      end
      count_d = cnt_base + 7'd1;
    end
    if (phase_q == gbfp_pkg::PH_BODY && count_d >= len) begin
      good    = (suma_d == cka_q) && (sumb_d == byte_q);
      phase_d = gbfp_pkg::PH_SYNC1;
      count_d = 7'd0;
    end
  end

  assign waddr = cnt_base;
  assign we    = go && (cw.act == gbfp_pkg::ACT_PROC) && store
                 && (cnt_base < gbfp_pkg::BUF_DEPTH);

  always_comb begin
    unique case (cw.br)
      gbfp_pkg::BR_GOOD:       br_true = good;
      gbfp_pkg::BR_K_ZERO:     br_true = (k_q == 2'd0);
      gbfp_pkg::BR_LAST_FIELD: br_true = last_field;
      default:                 br_true = 1'b1;
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (go) begin
      step_d = br_true ? cw.tgt_t : cw.tgt_f;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= gbfp_pkg::ST_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= byte_q;
    end
    if (cw.act == gbfp_pkg::ACT_READ) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= gbfp_pkg::PH_SYNC1;
      count_q <= 7'd0;
      type_q  <= 1'b0;
      suma_q  <= 8'd0;
      sumb_q  <= 8'd0;
      fld_q   <= 5'd0;
      k_q     <= 2'd0;
    end else if (go) begin
      unique case (cw.act)
        gbfp_pkg::ACT_PROC: begin
          phase_q <= phase_d;
          count_q <= count_d;
          type_q  <= type_d;
          suma_q  <= suma_d;
          sumb_q  <= sumb_d;
          fld_q   <= 5'd0;
        end
        gbfp_pkg::ACT_FSET:       k_q   <= size_m1;
        gbfp_pkg::ACT_ACC:        k_q   <= k_q - 2'd1;
        gbfp_pkg::ACT_EMIT_FIELD: fld_q <= fld_q + 5'd1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && cw.act == gbfp_pkg::ACT_TAKE) begin
      byte_q <= rx_byte_i;
    end
    if (go && cw.act == gbfp_pkg::ACT_PROC) begin
      cka_q <= cka_d;
    end
    if (cw.act == gbfp_pkg::ACT_FSET) begin
      acc_q <= 32'd0;
    end else if (cw.act == gbfp_pkg::ACT_ACC) begin
      acc_q <= {acc_q[23:0], rdata_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go && (cw.act == gbfp_pkg::ACT_EMIT_EMPTY
                        || cw.act == gbfp_pkg::ACT_EMIT_FIELD)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && cw.act == gbfp_pkg::ACT_EMIT_EMPTY) begin
      kind_q  <= gbfp_pkg::KIND_NONE;
      idx_q   <= 5'd0;
      value_q <= 32'd0;
      last_q  <= 1'b1;
    end else if (go && cw.act == gbfp_pkg::ACT_EMIT_FIELD) begin
      kind_q  <= type_q ? gbfp_pkg::KIND_REL : gbfp_pkg::KIND_POS;
      idx_q   <= fld_q;
      value_q <= acc_q;
      last_q  <= last_field;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_kind_o  = kind_q;
  assign field_index_o = idx_q;
  assign field_value_o = value_q;
  assign last_o        = last_q;

  `GBFP_ASSERT_NXT(a_take_then_proc, in_valid_i && !in_stall_o, step_q == gbfp_pkg::ST_PROC, "accepted byte not decoded next cycle")
  `GBFP_ASSERT_NXT(a_out_held, out_valid_q && out_stall_i, out_valid_q, "stalled result word dropped")
  `GBFP_ASSERT_IMP(a_field_range, step_q == gbfp_pkg::ST_EMIT, fld_q <= gbfp_pkg::POS_LAST_FIELD && (!type_q || fld_q <= gbfp_pkg::REL_LAST_FIELD), "field index beyond frame")
  `GBFP_ASSERT_IMP(a_body_count, phase_q == gbfp_pkg::PH_BODY, count_q >= 7'd2 && count_q < len, "body byte count out of frame")
  `GBFP_ASSERT_IMP(a_empty_word, out_valid_o && frame_kind_o == gbfp_pkg::KIND_NONE, last_o && field_value_o == 32'd0 && field_index_o == 5'd0, "empty result not clean")

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for gnss_binary_frame_parser: short byte sequences with
// typed results, then directed and random frames checked against a built-in parser.
// Depends on gbfp_pkg and the parser RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  index;
    logic [31:0] value;
    logic        last;
  } field_word_t;

  typedef struct packed {
    logic [7:0]  rx;
    field_word_t word;
  } byte_row_t;

  typedef enum int {
    FR_GOOD,
    FR_BAD_SUM_A,
    FR_BAD_SUM_B,
    FR_CUT
  } frame_flaw_e;

  localparam field_word_t EMPTY_WORD = '{gbfp_pkg::KIND_NONE, 5'd0, 32'd0, 1'b1};

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  frame_kind_o;
  logic [4:0]  field_index_o;
  logic [31:0] field_value_o;
  logic        last_o;

  gnss_binary_frame_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .frame_kind_o  (frame_kind_o),
    .field_index_o (field_index_o),
    .field_value_o (field_value_o),
    .last_o        (last_o)
  );

  // Sync, class and id mismatches, some followed by a byte that shows the
  // offending byte was dropped rather than rechecked as a first sync byte.
  byte_row_t sync_rows [24] = '{
    '{8'h00, EMPTY_WORD}, '{8'hFF, EMPTY_WORD}, '{gbfp_pkg::SYNC_SECOND, EMPTY_WORD},
    '{gbfp_pkg::SYNC_FIRST, EMPTY_WORD}, '{8'h00, EMPTY_WORD},
    '{gbfp_pkg::SYNC_FIRST, EMPTY_WORD}, '{gbfp_pkg::SYNC_FIRST, EMPTY_WORD},
    '{gbfp_pkg::SYNC_SECOND, EMPTY_WORD},
    '{gbfp_pkg::SYNC_FIRST, EMPTY_WORD}, '{gbfp_pkg::SYNC_SECOND, EMPTY_WORD},
    '{8'h02, EMPTY_WORD},
    '{gbfp_pkg::SYNC_FIRST, EMPTY_WORD}, '{gbfp_pkg::SYNC_SECOND, EMPTY_WORD},
    '{gbfp_pkg::CLASS_NAV, EMPTY_WORD}, '{8'h08, EMPTY_WORD},
    '{gbfp_pkg::SYNC_FIRST, EMPTY_WORD}, '{gbfp_pkg::SYNC_SECOND, EMPTY_WORD},
    '{gbfp_pkg::CLASS_NAV, EMPTY_WORD}, '{8'h3D, EMPTY_WORD},
    '{gbfp_pkg::SYNC_FIRST, EMPTY_WORD}, '{gbfp_pkg::SYNC_SECOND, EMPTY_WORD},
    '{gbfp_pkg::SYNC_FIRST, EMPTY_WORD},
    '{gbfp_pkg::SYNC_SECOND, EMPTY_WORD}, '{8'hFF, EMPTY_WORD}
  };

  int unsigned pvt_field_off [29] = '{4, 8, 10, 11, 12, 13, 14, 15, 16, 20, 24, 25, 26,
                                      27, 28, 32, 36, 40, 44, 48, 52, 56, 60, 64, 68,
                                      72, 76, 80, 88};
  int unsigned pvt_field_len [29] = '{4, 2, 1, 1, 1, 1, 1, 1, 4, 4, 1, 1, 1, 1, 4, 4, 4,
                                      4, 4, 4, 4, 4, 4, 4, 4, 4, 4, 2, 4};

  gbfp_pkg::phase_e rx_phase = gbfp_pkg::PH_SYNC1;
  logic [6:0]  body_count = '0;
  logic        rel_frame = 1'b0;
  logic [7:0]  frame_mem [98];
  logic [7:0]  fletcher_a = '0;
  logic [7:0]  fletcher_b = '0;

  field_word_t byte_words [$];
  field_word_t pending_words [$];
  field_word_t head_word;

  int errors = 0;
  int words_checked = 0;
  int bytes_sent = 0;
  int pvt_frames = 0;
  int rel_frames = 0;
  int send_idle_pct = 0;
  bit quiet = 1'b0;
  bit hold_request = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void store_frame_byte(input logic [7:0] b, input logic [6:0] sum_end);
    if (body_count < gbfp_pkg::BUF_DEPTH) frame_mem[body_count] = b;
    if (body_count < sum_end) begin
      fletcher_a = fletcher_a + b;
      fletcher_b = fletcher_b + fletcher_a;
    end
    body_count = body_count + 7'd1;
  endfunction

  function automatic logic [31:0] frame_le(input int unsigned off, input int unsigned nbytes);
    logic [31:0] v = '0;
    for (int k = int'(nbytes) - 1; k >= 0; k--) v = {v[23:0], frame_mem[off + k]};
    return v;
  endfunction

  // Advances the parser state by one byte and leaves the words it causes in byte_words.
  function automatic void parse_byte(input logic [7:0] b);
    logic [6:0] flen;
    logic [6:0] sum_end;
    logic       good;
    byte_words.delete();
    case (rx_phase)
      gbfp_pkg::PH_SYNC2: begin
        rx_phase = (b == gbfp_pkg::SYNC_SECOND) ? gbfp_pkg::PH_CLASS : gbfp_pkg::PH_SYNC1;
        body_count = '0;
      end
      gbfp_pkg::PH_CLASS: begin
        if (b == gbfp_pkg::CLASS_NAV) begin
          body_count = '0;
          fletcher_a = '0;
          fletcher_b = '0;
          store_frame_byte(b, gbfp_pkg::POS_CK);
          rx_phase = gbfp_pkg::PH_ID;
        end else begin
          rx_phase = gbfp_pkg::PH_SYNC1;
          body_count = '0;
        end
      end
      gbfp_pkg::PH_ID: begin
        if (b == gbfp_pkg::ID_POS || b == gbfp_pkg::ID_REL) begin
          rel_frame = (b == gbfp_pkg::ID_REL);
          store_frame_byte(b, rel_frame ? gbfp_pkg::REL_CK : gbfp_pkg::POS_CK);
          rx_phase = gbfp_pkg::PH_BODY;
        end else begin
          rx_phase = gbfp_pkg::PH_SYNC1;
          body_count = '0;
        end
      end
      gbfp_pkg::PH_BODY: begin
        flen = rel_frame ? gbfp_pkg::REL_LEN : gbfp_pkg::POS_LEN;
        sum_end = rel_frame ? gbfp_pkg::REL_CK : gbfp_pkg::POS_CK;
        store_frame_byte(b, sum_end);
        if (body_count >= flen) begin
          good = (fletcher_a == frame_mem[sum_end]) && (fletcher_b == frame_mem[sum_end + 1]);
          rx_phase = gbfp_pkg::PH_SYNC1;
          body_count = '0;
          if (good && rel_frame) begin
            rel_frames++;
            for (int k = 0; k < 3; k++)
              byte_words.push_back('{gbfp_pkg::KIND_REL, 5'(k), frame_le(12 + 4 * k, 4),
                                     1'(k == 2)});
          end else if (good) begin
            pvt_frames++;
            for (int k = 0; k < 29; k++)
              byte_words.push_back('{gbfp_pkg::KIND_POS, 5'(k),
                                     frame_le(pvt_field_off[k], pvt_field_len[k]),
                                     1'(k == 28)});
          end
        end
      end
      default: rx_phase = (b == gbfp_pkg::SYNC_FIRST) ? gbfp_pkg::PH_SYNC2
                                                      : gbfp_pkg::PH_SYNC1;
    endcase
    if (byte_words.size() == 0) byte_words.push_back(EMPTY_WORD);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input field_word_t typed_word = EMPTY_WORD);
    if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    parse_byte(b);
    if (typed) pending_words.push_back(typed_word);
    else foreach (byte_words[i]) pending_words.push_back(byte_words[i]);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic is_rel, input int fill, input frame_flaw_e flaw);
    logic [7:0] img [98];
    int flen;
    int sum_end;
    int stop;
    logic [7:0] sa;
    logic [7:0] sb;
    flen = is_rel ? gbfp_pkg::REL_LEN : gbfp_pkg::POS_LEN;
    sum_end = is_rel ? gbfp_pkg::REL_CK : gbfp_pkg::POS_CK;
    img[0] = gbfp_pkg::CLASS_NAV;
    img[1] = is_rel ? gbfp_pkg::ID_REL : gbfp_pkg::ID_POS;
    for (int i = 2; i < sum_end; i++) img[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    sa = '0;
    sb = '0;
    for (int i = 0; i < sum_end; i++) begin
      sa = sa + img[i];
      sb = sb + sa;
    end
    img[sum_end] = sa ^ ((flaw == FR_BAD_SUM_A) ? 8'($urandom_range(1, 255)) : 8'h00);
    img[sum_end + 1] = sb ^ ((flaw == FR_BAD_SUM_B) ? 8'($urandom_range(1, 255)) : 8'h00);
    stop = (flaw == FR_CUT) ? $urandom_range(1, flen - 1) : flen;
    send_byte(gbfp_pkg::SYNC_FIRST);
    send_byte(gbfp_pkg::SYNC_SECOND);
    for (int i = 0; i < stop; i++) send_byte(img[i]);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words.size() != 0);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got kind %0d index %0d value %0h",
                 $time, frame_kind_o, field_index_o, field_value_o);
      end else begin
        head_word = pending_words.pop_front();
        words_checked++;
        check_field("frame_kind", head_word.kind, frame_kind_o);
        check_field("field_index", head_word.index, field_index_o);
        check_field("field_value", head_word.value, field_value_o);
        check_field("last", head_word.last, last_o);
      end
    end
  end

  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 30) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int start;
    int pick;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 20;
    foreach (sync_rows[i]) send_byte(sync_rows[i].rx, 1'b1, sync_rows[i].word);
    send_frame(1'b1, 'hFF, FR_GOOD);
    send_frame(1'b0, -1, FR_GOOD);
    send_frame(1'b1, -1, FR_BAD_SUM_A);
    wait_drained();

    hold_request = 1'b1;
    start = bytes_sent;
    while (bytes_sent - start < 80) begin
      if (bytes_sent - start >= 55) quiet = 1'b1;
      send_idle_pct = 10 * $urandom_range(0, 4);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_frame(1'b1, -1, FR_GOOD);
      end else if (pick < 50) begin
        send_frame(1'b1, -1, $urandom_range(0, 1) ? FR_BAD_SUM_A : FR_BAD_SUM_B);
      end else if (pick < 60) begin
        send_frame(1'b1, -1, FR_CUT);
      end else if (pick < 80) begin
        send_byte(gbfp_pkg::SYNC_FIRST);
        if ($urandom_range(0, 1)) send_byte(gbfp_pkg::SYNC_SECOND);
        if ($urandom_range(0, 1)) send_byte(gbfp_pkg::CLASS_NAV);
        send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 6))
          send_byte(($urandom_range(0, 3) == 0) ? gbfp_pkg::SYNC_FIRST : 8'($urandom));
      end
    end
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d bytes and checked %0d result words.", bytes_sent, words_checked);
    $display("Decoded %0d position frames and %0d relative frames.", pvt_frames, rel_frames);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
